// ----- rtl/queue_watermark_hysteresis_defines.svh -----
// assertion macros used by the checker file
// no dependencies; clk and rst must be visible where they are used
`ifndef QUEUE_WATERMARK_HYSTERESIS_DEFINES_SVH
`define QUEUE_WATERMARK_HYSTERESIS_DEFINES_SVH

// same-cycle implication, disabled during reset
`define QWH_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define QWH_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/qwh_pkg.sv -----
// types and constants for the queue watermark block
// no dependencies
package qwh_pkg;

  localparam int QWH_DEPTH_BITS = 32;
  localparam int CFG_DATA_W     = 32;
  localparam int CFG_INDEX_W    = 2;
  localparam int PCT_W          = 7;
  localparam int THR_W          = 8;
  localparam int Q_STEPS        = 7;
  localparam int STEP_W         = $clog2(Q_STEPS);

  localparam logic [PCT_W-1:0] PCT_FULL      = 7'd100;
  localparam logic [THR_W-1:0] HIGH_RESET    = 8'd80;
  localparam logic [THR_W-1:0] RECOVER_RESET = 8'd50;

  localparam logic [CFG_INDEX_W-1:0] CFG_CAPACITY = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_HIGH     = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_RECOVER  = 2'd2;

  typedef enum logic [1:0] {
    REASON_NONE      = 2'd0,
    REASON_FULL      = 2'd1,
    REASON_FILLING   = 2'd2,
    REASON_RECOVERED = 2'd3
  } qwh_reason_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCALE,
    S_DIV,
    S_RESULT
  } qwh_state_t;

  typedef struct packed {
    logic done;
    logic full;
  } qwh_scale_stat_t;

  typedef struct packed {
    logic             done;
    logic [PCT_W-1:0] quot;
  } qwh_div_stat_t;

endpackage

// ----- rtl/qwh_scale.sv -----
// bit-serial multiply of depth by 100 and depth >= capacity compare
// depends on qwh_pkg
module qwh_scale
  import qwh_pkg::*;
#(
  parameter int DEPTH_BITS = QWH_DEPTH_BITS
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic [DEPTH_BITS-1:0]   depth,
  input  logic [DEPTH_BITS-1:0]   cap,
  output logic [DEPTH_BITS+6:0]   prod,
  output qwh_scale_stat_t         stat
);

  localparam int NW = DEPTH_BITS + 7;
  localparam int CW = $clog2(NW);

  logic [DEPTH_BITS-1:0] d_sr;
  logic [DEPTH_BITS-1:0] c_sr;
  logic [5:0]            win;
  logic [1:0]            carry;
  logic                  borrow;
  logic [NW-1:0]         n_sr;
  logic [CW-1:0]         cnt;
  logic                  busy;
  logic                  done;

  logic       dk;
  logic       cb;
  logic [2:0] sum;

  // 100*d = (d<<6) + (d<<5) + (d<<2), win[i] holds d[k-1-i]
  assign dk  = d_sr[0];
  assign cb  = c_sr[0];
  assign sum = {2'b00, win[1]} + {2'b00, win[4]} + {2'b00, win[5]} + {1'b0, carry};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        if (cnt == CW'(NW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      d_sr   <= depth;
      c_sr   <= cap;
      win    <= '0;
      carry  <= '0;
      borrow <= 1'b0;
    end else if (busy) begin
      d_sr   <= {1'b0, d_sr[DEPTH_BITS-1:1]};
      c_sr   <= {1'b0, c_sr[DEPTH_BITS-1:1]};
      win    <= {win[4:0], dk};
      carry  <= sum[2:1];
      n_sr   <= {sum[0], n_sr[NW-1:1]};
      // borrow of depth - cap; both streams run out as zeros
      borrow <= (~dk & cb) | (~(dk ^ cb) & borrow);
    end
  end

  assign prod      = n_sr;
  assign stat.done = done;
  assign stat.full = ~borrow;

endmodule

// ----- rtl/qwh_div.sv -----
// bit-serial restoring divider giving floor(prod / cap) for a quotient below 128
// depends on qwh_pkg
module qwh_div
  import qwh_pkg::*;
#(
  parameter int DEPTH_BITS = QWH_DEPTH_BITS
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic [DEPTH_BITS+6:0]   prod,
  input  logic [DEPTH_BITS-1:0]   cap,
  output qwh_div_stat_t           stat
);

  localparam int W   = DEPTH_BITS;
  localparam int BCW = $clog2(W + 1);
  localparam int LOW = Q_STEPS - 1;

  logic [W:0]        t_sr;
  logic [W:0]        df_sr;
  logic [W-1:0]      c_sr;
  logic [LOW-1:0]    nlow;
  logic [PCT_W-1:0]  q;
  logic              borrow;
  logic [BCW-1:0]    bcnt;
  logic [STEP_W-1:0] step;
  logic              busy;
  logic              done;

  logic       last_bit;
  logic       tb;
  logic       cb;
  logic       dbit;
  logic       bnext;
  logic [W:0] rot;
  logic [W:0] dfn;
  logic [W:0] sel;

  assign last_bit = (bcnt == BCW'(W));
  assign tb       = t_sr[0];
  assign cb       = last_bit ? 1'b0 : c_sr[0];
  assign dbit     = tb ^ cb ^ borrow;
  assign bnext    = (~tb & cb) | (~(tb ^ cb) & borrow);
  assign rot      = {tb, t_sr[W:1]};
  assign dfn      = {dbit, df_sr[W:1]};
  // restore on borrow, else keep the difference
  assign sel      = bnext ? rot : dfn;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      bcnt <= '0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        bcnt <= '0;
        step <= '0;
      end else if (busy) begin
        if (last_bit) begin
          bcnt <= '0;
          if (step == STEP_W'(Q_STEPS - 1)) begin
            busy <= 1'b0;
            done <= 1'b1;
          end else begin
            step <= step + 1'b1;
          end
        end else begin
          bcnt <= bcnt + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      t_sr   <= prod[W+6:LOW];
      nlow   <= prod[LOW-1:0];
      c_sr   <= cap;
      q      <= '0;
      borrow <= 1'b0;
    end else if (busy) begin
      df_sr <= dfn;
      if (last_bit) begin
        t_sr   <= {sel[W-1:0], nlow[LOW-1]};
        nlow   <= {nlow[LOW-2:0], 1'b0};
        q      <= {q[PCT_W-2:0], ~bnext};
        borrow <= 1'b0;
      end else begin
        t_sr   <= rot;
        c_sr   <= {c_sr[0], c_sr[W-1:1]};
        borrow <= bnext;
      end
    end
  end

  assign stat.done = done;
  assign stat.quot = q;

endmodule

// ----- rtl/queue_watermark_hysteresis.sv -----
// top level of the queue watermark block with hysteresis flag and peak tracking
// depends on qwh_pkg, qwh_scale, qwh_div
//
//   channel  signals                                   direction
//   obs      obs_valid/obs_ready, action, depth        in
//   res      res_valid/res_ready, reason, fill/peak    out
//   cfg      cfg_wen, cfg_index, cfg_wdata             in, write only
//
// clear action or zero capacity: no arithmetic pass, the FSM goes straight to the result state
// depth at or above capacity: the result follows the serial x100 pass and its compare
// otherwise the bit-serial divider runs after the x100 pass before the result is loaded
// one item in flight; a waiting result sits in the output register while the next one runs
// synchronous reset clears state, flags and config registers to their reset values; payload registers are not reset
module queue_watermark_hysteresis
  import qwh_pkg::*;
#(
  parameter int DEPTH_BITS = QWH_DEPTH_BITS
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   obs_valid,
  output logic                   obs_ready,
  input  logic                   action,
  input  logic [DEPTH_BITS-1:0]  depth,
  output logic                   res_valid,
  input  logic                   res_ready,
  output logic [1:0]             reason,
  output logic [PCT_W-1:0]       fill_percent,
  output logic [PCT_W-1:0]       peak_percent,
  input  logic                   cfg_wen,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

  logic [CFG_DATA_W-1:0] queue_capacity;
  logic [THR_W-1:0]      high_percent;
  logic [THR_W-1:0]      recover_percent;
  logic                  above_high;
  logic [PCT_W-1:0]      peak_fill;

  qwh_state_t state, state_next;

  logic [DEPTH_BITS-1:0] cap_w;
  logic                  cap_zero;
  logic [DEPTH_BITS+6:0] prod;
  qwh_scale_stat_t       scale_stat;
  qwh_div_stat_t         div_stat;

  logic             scale_start;
  logic             div_start;
  logic             res_load;
  logic             obs_beat;

  logic [PCT_W-1:0] pct_q;
  logic             full_q;
  logic             calc_q;
  logic             clr_q;

  qwh_reason_t      reason_n;
  qwh_reason_t      reason_q;
  logic [PCT_W-1:0] peak_n;
  logic             above_n;

  assign cap_w    = DEPTH_BITS'(queue_capacity);
  assign cap_zero = (cap_w == '0);
  assign obs_beat = obs_valid && obs_ready;

  qwh_scale #(.DEPTH_BITS(DEPTH_BITS)) u_scale (
    .clk   (clk),
    .rst   (rst),
    .start (scale_start),
    .depth (depth),
    .cap   (cap_w),
    .prod  (prod),
    .stat  (scale_stat)
  );

  qwh_div #(.DEPTH_BITS(DEPTH_BITS)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .prod  (prod),
    .cap   (cap_w),
    .stat  (div_stat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    obs_ready   = 1'b0;
    scale_start = 1'b0;
    div_start   = 1'b0;
    res_load    = 1'b0;
    unique case (state)
      S_IDLE: begin
        obs_ready = 1'b1;
        if (obs_valid) begin
          if (!action && !cap_zero) begin
            scale_start = 1'b1;
            state_next  = S_SCALE;
          end else begin
            state_next  = S_RESULT;
          end
        end
      end
      S_SCALE: begin
        if (scale_stat.done) begin
          if (scale_stat.full) begin
            state_next = S_RESULT;
          end else begin
            div_start  = 1'b1;
            state_next = S_DIV;
          end
        end
      end
      S_DIV: begin
        if (div_stat.done) begin
          state_next = S_RESULT;
        end
      end
      S_RESULT: begin
        if (!res_valid || res_ready) begin
          res_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // item bookkeeping, payload only
  always_ff @(posedge clk) begin
    if (obs_beat) begin
      clr_q  <= action;
      calc_q <= !action && !cap_zero;
      full_q <= 1'b0;
      pct_q  <= '0;
    end else if (state == S_SCALE && scale_stat.done && scale_stat.full) begin
      full_q <= 1'b1;
      pct_q  <= PCT_FULL;
    end else if (state == S_DIV && div_stat.done) begin
      pct_q  <= div_stat.quot;
    end
  end

  always_comb begin
    reason_n = REASON_NONE;
    peak_n   = peak_fill;
    above_n  = above_high;
    if (clr_q) begin
      peak_n  = '0;
      above_n = 1'b0;
    end else if (calc_q) begin
      if (pct_q > peak_fill) begin
        peak_n = pct_q;
      end
      priority if (full_q) begin
        above_n  = 1'b1;
        reason_n = REASON_FULL;
      end else if ({1'b0, pct_q} >= high_percent) begin
        if (!above_high) begin
          above_n  = 1'b1;
          reason_n = REASON_FILLING;
        end
      end else if ({1'b0, pct_q} < recover_percent) begin
        if (above_high) begin
          above_n  = 1'b0;
          reason_n = REASON_RECOVERED;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      above_high <= 1'b0;
      peak_fill  <= '0;
      res_valid  <= 1'b0;
    end else begin
      if (res_load) begin
        above_high <= above_n;
        peak_fill  <= peak_n;
        res_valid  <= 1'b1;
      end else if (res_ready) begin
        res_valid  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      reason_q     <= reason_n;
      fill_percent <= pct_q;
      peak_percent <= peak_n;
    end
  end

  assign reason = reason_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      queue_capacity  <= '0;
      high_percent    <= HIGH_RESET;
      recover_percent <= RECOVER_RESET;
    end else if (cfg_wen) begin
      case (cfg_index)
        CFG_CAPACITY: queue_capacity  <= cfg_wdata;
        CFG_HIGH:     high_percent    <= cfg_wdata[THR_W-1:0];
        CFG_RECOVER:  recover_percent <= cfg_wdata[THR_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

// ----- rtl/qwh_checker.sv -----
// port-level checks for the queue watermark block, bound to the top level
// depends on qwh_pkg and queue_watermark_hysteresis_defines.svh
`include "queue_watermark_hysteresis_defines.svh"

module qwh_checker
  import qwh_pkg::*;
#(
  parameter int DEPTH_BITS = QWH_DEPTH_BITS
) (
  input logic                   clk,
  input logic                   rst,
  input logic                   obs_valid,
  input logic                   obs_ready,
  input logic                   action,
  input logic [DEPTH_BITS-1:0]  depth,
  input logic                   res_valid,
  input logic                   res_ready,
  input logic [1:0]             reason,
  input logic [PCT_W-1:0]       fill_percent,
  input logic [PCT_W-1:0]       peak_percent
);

  // a stalled result beat holds
  `QWH_ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid && $stable(reason) && $stable(fill_percent) && $stable(peak_percent), "result beat changed while stalled")

  // a waiting input beat holds
  `QWH_ASSERT_NEXT(a_obs_hold, obs_valid && !obs_ready, obs_valid && $stable(action) && $stable(depth), "input beat changed while waiting")

  // the peak never trails the percent it was raised by
  `QWH_ASSERT_NOW(a_peak_ge_fill, res_valid, peak_percent >= fill_percent, "peak below fill percent")

  // full always reports a saturated percent and peak
  `QWH_ASSERT_NOW(a_full_pct, res_valid && reason == REASON_FULL, fill_percent == PCT_FULL && peak_percent == PCT_FULL, "full without 100 percent")

  // one item at a time: an accepted beat closes the input for the next cycle
  `QWH_ASSERT_NEXT(a_one_item, obs_valid && obs_ready, !obs_ready, "input taken while an item is in flight")

endmodule

bind queue_watermark_hysteresis qwh_checker #(.DEPTH_BITS(DEPTH_BITS)) u_checker (.*);

// ----- tb/tb_queue_watermark_hysteresis.sv -----
// self-checking testbench for queue_watermark_hysteresis: directed watermark cases, then
// random config phases with depth walks; depends on qwh_pkg and the rtl top level
`timescale 1ns / 1ps

module tb_queue_watermark_hysteresis;
  import qwh_pkg::*;

  localparam int DW             = QWH_DEPTH_BITS;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int PHASE_COUNT    = 12;
  localparam int PHASE_BEATS    = 128;

  typedef struct {
    qwh_reason_t      reason;
    logic [PCT_W-1:0] fill;
    logic [PCT_W-1:0] peak;
  } watermark_rep_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   obs_valid;
  logic                   obs_ready;
  logic                   action;
  logic [DW-1:0]          depth;
  logic                   res_valid;
  logic                   res_ready = 1'b0;
  logic [1:0]             reason;
  logic [PCT_W-1:0]       fill_percent;
  logic [PCT_W-1:0]       peak_percent;
  logic                   cfg_wen;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_wdata;

  // predictor copy of registers and state
  logic [DW-1:0]    cap_m;
  logic [THR_W-1:0] high_m;
  logic [THR_W-1:0] recover_m;
  logic             over_high_m;
  logic [PCT_W-1:0] peak_m;

  watermark_rep_t pending_reports[$];
  watermark_rep_t want;
  int             mismatch_cnt = 0;
  int             quiet_cycles = 0;
  int             burst_left   = 0;
  int             stall_cyc    = 0;
  int             stall_mode   = 0;
  int             stall_left   = 0;
  logic           ready_level  = 1'b0;

  queue_watermark_hysteresis dut (
    .clk          (clk),
    .rst          (rst),
    .obs_valid    (obs_valid),
    .obs_ready    (obs_ready),
    .action       (action),
    .depth        (depth),
    .res_valid    (res_valid),
    .res_ready    (res_ready),
    .reason       (reason),
    .fill_percent (fill_percent),
    .peak_percent (peak_percent),
    .cfg_wen      (cfg_wen),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata)
  );

  always #5 clk = ~clk;

  task automatic report_mismatch(input string msg);
    $display("ERROR at %0t ns: %s", $time, msg);
    mismatch_cnt++;
  endtask

  task automatic predict_watermark(input logic act, input logic [DW-1:0] d);
    watermark_rep_t   rep;
    logic [63:0]      scaled;
    logic [PCT_W-1:0] pct;
    rep.reason = REASON_NONE;
    pct = '0;
    if (act) begin
      peak_m = '0;
      over_high_m = 1'b0;
    end else if (cap_m != 0) begin
      if (d >= cap_m) begin
        pct = PCT_FULL;
      end else begin
        // exact percent, product kept in 64 bits
        scaled = ({32'd0, d} * 64'd100) / {32'd0, cap_m};
        pct = scaled[PCT_W-1:0];
      end
      if (pct > peak_m) peak_m = pct;
      if (d >= cap_m) begin
        over_high_m = 1'b1;
        rep.reason = REASON_FULL;
      end else if ({1'b0, pct} >= high_m) begin
        if (!over_high_m) begin
          over_high_m = 1'b1;
          rep.reason = REASON_FILLING;
        end
      end else if ({1'b0, pct} < recover_m) begin
        if (over_high_m) begin
          over_high_m = 1'b0;
          rep.reason = REASON_RECOVERED;
        end
      end
    end
    rep.fill = pct;
    rep.peak = peak_m;
    pending_reports.push_back(rep);
  endtask

  // one observe/clear beat; valid stays up across a burst
  task automatic send_beat(input logic act, input logic [DW-1:0] d);
    int gap;
    if (burst_left == 0)
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 10);
    @(negedge clk);
    obs_valid <= 1'b1;
    action    <= act;
    depth     <= d;
    @(posedge clk);
    while (!obs_ready) @(posedge clk);
    predict_watermark(act, d);
    burst_left--;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 300) : $urandom_range(0, 12);
      if (gap > 0) begin
        @(negedge clk);
        obs_valid <= 1'b0;
        action    <= 1'($urandom_range(0, 1));
        depth     <= $urandom;
        repeat (gap - 1) @(negedge clk);
      end
    end
  endtask

  task automatic drain_results();
    @(negedge clk);
    obs_valid <= 1'b0;
    burst_left = 0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_cfg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_wen   <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_wen   <= 1'b0;
    case (idx)
      CFG_CAPACITY: cap_m = val[DW-1:0];
      CFG_HIGH:     high_m = val[THR_W-1:0];
      CFG_RECOVER:  recover_m = val[THR_W-1:0];
      default: ;
    endcase
  endtask

  // reset values: capacity zero, so nothing fires and peak stays put
  task automatic test_zero_capacity();
    send_beat(1'b0, '0);
    send_beat(1'b0, '1);
    send_beat(1'b1, '1);
    drain_results();
  endtask

  task automatic test_hysteresis();
    write_cfg(CFG_CAPACITY, 32'd100);
    send_beat(1'b0, 32'd0);
    send_beat(1'b0, 32'd79);
    send_beat(1'b0, 32'd80);
    send_beat(1'b0, 32'd95);
    send_beat(1'b0, 32'd60);
    send_beat(1'b0, 32'd49);
    send_beat(1'b0, 32'd30);
    send_beat(1'b0, 32'd100);
    send_beat(1'b0, 32'hFFFF_FFFF);
    send_beat(1'b0, 32'd85);
    send_beat(1'b0, 32'd10);
    send_beat(1'b1, 32'h5A5A_A5A5);
    drain_results();
  endtask

  task automatic test_capacity_extremes();
    write_cfg(CFG_CAPACITY, 32'hFFFF_FFFF);
    write_cfg(CFG_HIGH, 8'd100);
    write_cfg(CFG_RECOVER, 8'd0);
    send_beat(1'b0, 32'hFFFF_FFFE);
    send_beat(1'b0, 32'hFFFF_FFFF);
    send_beat(1'b0, 32'd0);
    drain_results();
    write_cfg(CFG_CAPACITY, 32'd1);
    send_beat(1'b0, 32'd0);
    send_beat(1'b0, 32'd1);
    drain_results();
  endtask

  task automatic test_threshold_extremes();
    // thresholds past 100: only full raises the flag
    write_cfg(CFG_CAPACITY, 32'd3);
    write_cfg(CFG_HIGH, 8'd255);
    write_cfg(CFG_RECOVER, 8'd255);
    send_beat(1'b0, 32'd2);
    send_beat(1'b0, 32'd3);
    send_beat(1'b0, 32'd1);
    drain_results();
    // zero high threshold fires filling once
    write_cfg(CFG_HIGH, 8'd0);
    write_cfg(CFG_RECOVER, 8'd0);
    send_beat(1'b0, 32'd0);
    send_beat(1'b0, 32'd1);
    drain_results();
    // capacity back to zero keeps the peak
    write_cfg(CFG_CAPACITY, 32'd0);
    send_beat(1'b0, 32'd5);
    drain_results();
  endtask

  task automatic test_random_phases();
    logic [CFG_DATA_W-1:0] cap;
    int                    hi;
    int                    rec;
    int                    lvl;
    int                    sel;
    logic [63:0]           scaled;
    for (int p = 0; p < PHASE_COUNT; p++) begin
      case ($urandom_range(0, 7))
        0:       cap = $urandom_range(1, 8);
        1:       cap = $urandom_range(9, 200);
        2, 3:    cap = $urandom_range(200, 100000);
        4, 5:    cap = $urandom;
        6:       cap = 32'hFFFF_FFFF - $urandom_range(0, 3);
        default: cap = ($urandom_range(0, 3) == 0) ? 32'd0 : $urandom_range(1, 1000);
      endcase
      if (p == 0) cap = 32'hFFFF_FFFF;
      if (p == 1) cap = 32'd1;
      case ($urandom_range(0, 5))
        0, 1, 2: begin
          hi  = $urandom_range(40, 100);
          rec = $urandom_range(0, hi);
        end
        3: begin
          hi  = $urandom_range(0, 255);
          rec = $urandom_range(0, 255);
        end
        4: begin
          hi  = $urandom_range(0, 1) ? 255 : 0;
          rec = $urandom_range(0, 1) ? 255 : 0;
        end
        default: begin
          hi  = $urandom_range(101, 255);
          rec = $urandom_range(0, 100);
        end
      endcase
      write_cfg(CFG_CAPACITY, cap);
      write_cfg(CFG_HIGH, hi[THR_W-1:0]);
      write_cfg(CFG_RECOVER, rec[THR_W-1:0]);
      lvl = $urandom_range(0, 110);
      repeat (PHASE_BEATS) begin
        // fill level walks up and down to cross both thresholds
        lvl = lvl + $urandom_range(0, 30) - 15;
        if (lvl < 0) lvl = 0;
        if (lvl > 110) lvl = 110;
        sel = $urandom_range(0, 19);
        if (sel == 0) begin
          send_beat(1'b1, $urandom);
        end else if (sel == 1) begin
          send_beat(1'b0, $urandom);
        end else if (sel == 2) begin
          send_beat(1'b0, cap_m + $urandom_range(0, 2) - 1);
        end else begin
          scaled = ({32'd0, cap_m} * 64'(lvl)) / 64'd100 + 64'($urandom_range(0, 2));
          if (scaled > 64'hFFFF_FFFF) scaled = 64'hFFFF_FFFF;
          send_beat(1'b0, scaled[DW-1:0]);
        end
        // sender holds off until everything has drained
        if ($urandom_range(0, 39) == 0) drain_results();
      end
      drain_results();
    end
  endtask

  // receiver stall pattern, in one of four randomly redrawn modes
  always @(negedge clk) begin
    stall_cyc++;
    if (stall_cyc % 300 == 0) stall_mode = $urandom_range(0, 3);
    case (stall_mode)
      0: res_ready <= 1'b1;
      1: res_ready <= 1'($urandom_range(0, 1));
      2: begin
        if (stall_left == 0) begin
          stall_left = $urandom_range(1, 40);
          ready_level = ~ready_level;
        end
        stall_left--;
        res_ready <= ready_level;
      end
      default: res_ready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  always @(posedge clk) begin
    if (!rst && res_valid && res_ready) begin
      if (pending_reports.size() == 0) begin
        report_mismatch("result beat with nothing expected");
      end else begin
        want = pending_reports.pop_front();
        if (reason !== want.reason)
          report_mismatch($sformatf("reason got %0d expected %0d", reason, want.reason));
        if (fill_percent !== want.fill)
          report_mismatch($sformatf("fill_percent got %0d expected %0d",
                                    fill_percent, want.fill));
        if (peak_percent !== want.peak)
          report_mismatch($sformatf("peak_percent got %0d expected %0d",
                                    peak_percent, want.peak));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (obs_valid && obs_ready) || (res_valid && res_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no beat for %0d cycles", WATCHDOG_LIMIT);
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    obs_valid   = 1'b0;
    action      = 1'b0;
    depth       = '0;
    cfg_wen     = 1'b0;
    cfg_index   = CFG_CAPACITY;
    cfg_wdata   = '0;
    cap_m       = '0;
    high_m      = HIGH_RESET;
    recover_m   = RECOVER_RESET;
    over_high_m = 1'b0;
    peak_m      = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_zero_capacity();
    test_hysteresis();
    test_capacity_extremes();
    test_threshold_extremes();
    test_random_phases();
    drain_results();
    repeat (300) @(posedge clk);
    if (mismatch_cnt == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
